// File: design/endpoint_text_parser_assert.svh
// assertion macros for the endpoint text parser
`ifndef ENDPOINT_TEXT_PARSER_ASSERT_SVH
`define ENDPOINT_TEXT_PARSER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define EPT_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent at the same edge
`define EPT_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/ept_pkg.sv
package ept_pkg;

	typedef enum logic [1:0] {
		VERDICT_IPV4_OK,
		VERDICT_DNS_OK,
		VERDICT_DNS_NOT_CANONICAL,
		VERDICT_DNS_BAD_PORT
	} verdict_t;

	typedef enum logic [2:0] {
		REASON_OK,
		REASON_COLON_COUNT,
		REASON_MALFORMED,
		REASON_OCTET,
		REASON_EXTRA_OCTETS,
		REASON_PORT,
		REASON_ZERO_ADDR
	} ipv4_reason_t;

	typedef struct packed {
		logic nonempty;
		logic multi;
		logic leadzero;
		logic badchar;
	} field_flags_t;

	typedef struct packed {
		logic valid;
		logic numeric;
		logic prev_hyph;
		logic start_hyph;
		logic too_long;
	} dns_flags_t;

	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CHAR_DOT    = 8'h2e;
	localparam logic [7:0] CHAR_COLON  = 8'h3a;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2d;

	localparam logic [6:0] MAX_LABEL_BYTES = 7'd63;
	localparam logic [6:0] LABEL_SAT       = 7'd64;
	localparam logic [7:0] MAX_NAME_BYTES  = 8'd253;
	localparam logic [7:0] HOST_COUNT_MAX  = 8'd255;
	localparam logic [7:0] HOSTNAME_LEN_RESET = 8'd253;
	localparam logic [1:0] LAST_OCTET = 2'd3;
	localparam logic [1:0] COLON_SAT  = 2'd2;
	localparam logic [1:0] COLON_ONE  = 2'd1;
	localparam logic [11:0] OCTET_LIMIT = 12'd256;
	localparam logic [20:0] PORT_LIMIT  = 21'd65536;

	localparam dns_flags_t DNS_FLAGS_RESET = '{valid: 1'b1, numeric: 1'b1, prev_hyph: 1'b0,
		start_hyph: 1'b0, too_long: 1'b0};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic ipv4_reason_t keep_reason(input ipv4_reason_t cur, input ipv4_reason_t r);
		return (cur == REASON_OK) ? r : cur;
	endfunction

	function automatic logic field_ok(input field_flags_t ff, input logic in_range);
		return ff.nonempty && !ff.badchar && !(ff.multi && ff.leadzero) && in_range;
	endfunction

	function automatic field_flags_t field_take(input field_flags_t ff, input logic [7:0] c);
		field_flags_t r;
		r = ff;
		if (ff.nonempty) begin
			r.multi = 1'b1;
		end else begin
			r.nonempty = 1'b1;
			if (c == CHAR_ZERO) begin
				r.leadzero = 1'b1;
			end
		end
		if (!is_digit(c)) begin
			r.badchar = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [8:0] octet_take(input logic [8:0] acc, input logic [7:0] c);
		logic [11:0] wide;
		logic [11:0] prod;
		wide = {3'b000, acc};
		prod = (wide << 3) + (wide << 1) + {8'h00, c[3:0]};
		if (!is_digit(c) || acc[8]) begin
			return acc;
		end else if (prod > OCTET_LIMIT) begin
			return OCTET_LIMIT[8:0];
		end else begin
			return prod[8:0];
		end
	endfunction

	function automatic logic [16:0] port_take(input logic [16:0] acc, input logic [7:0] c);
		logic [20:0] wide;
		logic [20:0] prod;
		wide = {4'h0, acc};
		prod = (wide << 3) + (wide << 1) + {17'h00000, c[3:0]};
		if (!is_digit(c) || acc[16]) begin
			return acc;
		end else if (prod > PORT_LIMIT) begin
			return PORT_LIMIT[16:0];
		end else begin
			return prod[16:0];
		end
	endfunction

	function automatic logic label_bad(input logic [6:0] len, input dns_flags_t df);
		return (len == 7'd0) || (len > MAX_LABEL_BYTES) || df.start_hyph || df.prev_hyph;
	endfunction

endpackage

// File: design/ept_if.sv
interface ept_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       is_last;

	modport source (output valid, output text_char, output is_last, input ready);
	modport sink (input valid, input text_char, input is_last, output ready);
endinterface

interface ept_result_if;
	logic                  valid;
	logic                  ready;
	ept_pkg::verdict_t     verdict;
	ept_pkg::ipv4_reason_t ipv4_reason;
	logic [31:0]           ipv4_address;
	logic [15:0]           port_number;
	logic [7:0]            hostname_length;

	modport source (output valid, output verdict, output ipv4_reason, output ipv4_address,
		output port_number, output hostname_length, input ready);
	modport sink (input valid, input verdict, input ipv4_reason, input ipv4_address,
		input port_number, input hostname_length, output ready);
endinterface

// File: design/endpoint_text_parser.sv
// channel  | direction | payload
// text     | sink      | text_char, is_last
// result   | source    | verdict, ipv4_reason, ipv4_address, port_number, hostname_length
// cfg      | write     | max_hostname_length (cfg_wr_data)
//
// one character per cycle while the input is not stalled; a result passes from its
// last character through the input register, then the result register
// arst_n clears all parse state and sets max_hostname_length to 253
// a last character waits in the input register while a prior result is not taken;
// other characters keep flowing while a result waits
module endpoint_text_parser (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [7:0] cfg_wr_data,
	ept_text_if.sink text,
	ept_result_if.source result
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       is_last_s1;
	logic       advance;

	logic [7:0] max_len_q;

	logic                  phase_q, phase_d;
	logic [1:0]            colon_q, colon_d;
	logic [1:0]            octet_idx_q, octet_idx_d;
	logic [8:0]            octet_acc_q, octet_acc_d;
	logic [31:0]           addr_q, addr_d;
	ept_pkg::field_flags_t ff_q, ff_d;
	ept_pkg::ipv4_reason_t reason_q, reason_d;
	logic [16:0]           port_acc_q, port_acc_d;
	logic [7:0]            host_cnt_q, host_cnt_d;
	logic [6:0]            label_len_q, label_len_d;
	ept_pkg::dns_flags_t   dns_q, dns_d;

	logic is_dot, is_hyph, is_lower, is_dig;
	logic port_ok;

	ept_pkg::verdict_t     verdict_d;
	ept_pkg::ipv4_reason_t reason_out_d;
	logic [31:0]           addr_out_d;
	logic [15:0]           port_out_d;
	logic [7:0]            hlen_out_d;

	logic                  valid_s2;
	ept_pkg::verdict_t     verdict_s2;
	ept_pkg::ipv4_reason_t ipv4_reason_s2;
	logic [31:0]           ipv4_address_s2;
	logic [15:0]           port_number_s2;
	logic [7:0]            hostname_length_s2;

	assign advance = valid_s1 && (!is_last_s1 || !valid_s2 || result.ready);
	assign text.ready = !valid_s1 || advance;

	assign is_dot = (char_s1 == ept_pkg::CHAR_DOT);
	assign is_hyph = (char_s1 == ept_pkg::CHAR_HYPHEN);
	assign is_lower = (char_s1 >= ept_pkg::CHAR_LOWER_A) && (char_s1 <= ept_pkg::CHAR_LOWER_Z);
	assign is_dig = ept_pkg::is_digit(char_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= ept_pkg::HOSTNAME_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.text_char;
			is_last_s1 <= text.is_last;
		end
	end

	// per-character update
	always_comb begin
		phase_d = phase_q;
		colon_d = colon_q;
		octet_idx_d = octet_idx_q;
		octet_acc_d = octet_acc_q;
		addr_d = addr_q;
		ff_d = ff_q;
		reason_d = reason_q;
		port_acc_d = port_acc_q;
		host_cnt_d = host_cnt_q;
		label_len_d = label_len_q;
		dns_d = dns_q;
		if (char_s1 == ept_pkg::CHAR_COLON) begin
			if (!phase_q) begin
				// close the host part
				if (octet_idx_q != ept_pkg::LAST_OCTET || !ff_q.nonempty) begin
					reason_d = ept_pkg::keep_reason(reason_q, ept_pkg::REASON_MALFORMED);
				end else if (!ept_pkg::field_ok(ff_q, !octet_acc_q[8])) begin
					reason_d = ept_pkg::keep_reason(reason_q, ept_pkg::REASON_OCTET);
				end else begin
					addr_d = {addr_q[23:0], octet_acc_q[7:0]};
				end
				if (ept_pkg::label_bad(label_len_q, dns_q) || dns_q.too_long ||
					host_cnt_q > max_len_q || host_cnt_q > ept_pkg::MAX_NAME_BYTES) begin
					dns_d.valid = 1'b0;
				end
				label_len_d = '0;
				dns_d.start_hyph = 1'b0;
				dns_d.prev_hyph = 1'b0;
				ff_d = '0;
				port_acc_d = '0;
				phase_d = 1'b1;
			end
			if (colon_q != ept_pkg::COLON_SAT) begin
				colon_d = colon_q + 2'd1;
			end
		end else if (!phase_q) begin
			if (is_dot && octet_idx_q != ept_pkg::LAST_OCTET) begin
				if (!ept_pkg::field_ok(ff_q, !octet_acc_q[8])) begin
					reason_d = ept_pkg::keep_reason(reason_q, ept_pkg::REASON_OCTET);
				end
				addr_d = {addr_q[23:0], octet_acc_q[7:0]};
				octet_idx_d = octet_idx_q + 2'd1;
				ff_d = '0;
				octet_acc_d = '0;
			end else begin
				ff_d = ept_pkg::field_take(ff_q, char_s1);
				octet_acc_d = ept_pkg::octet_take(octet_acc_q, char_s1);
			end
			if (host_cnt_q != ept_pkg::HOST_COUNT_MAX) begin
				host_cnt_d = host_cnt_q + 8'd1;
			end else begin
				dns_d.too_long = 1'b1;
			end
			if (!is_dig && !is_dot) begin
				dns_d.numeric = 1'b0;
			end
			if (is_dot) begin
				if (ept_pkg::label_bad(label_len_q, dns_q)) begin
					dns_d.valid = 1'b0;
				end
				label_len_d = '0;
				dns_d.start_hyph = 1'b0;
				dns_d.prev_hyph = 1'b0;
			end else begin
				if (label_len_q == 7'd0 && is_hyph) begin
					dns_d.start_hyph = 1'b1;
				end
				if (label_len_q != ept_pkg::LABEL_SAT) begin
					label_len_d = label_len_q + 7'd1;
				end
				dns_d.prev_hyph = is_hyph;
				if (!is_lower && !is_dig && !is_hyph) begin
					dns_d.valid = 1'b0;
				end
			end
		end else begin
			ff_d = ept_pkg::field_take(ff_q, char_s1);
			port_acc_d = ept_pkg::port_take(port_acc_q, char_s1);
		end
	end

	// verdict from the updated state
	always_comb begin
		port_ok = ept_pkg::field_ok(ff_d, !port_acc_d[16]) && (port_acc_d != 17'd0);
		verdict_d = ept_pkg::VERDICT_DNS_NOT_CANONICAL;
		reason_out_d = ept_pkg::REASON_COLON_COUNT;
		addr_out_d = '0;
		port_out_d = '0;
		hlen_out_d = '0;
		if (colon_d == ept_pkg::COLON_ONE) begin
			reason_out_d = reason_d;
			if (reason_out_d == ept_pkg::REASON_OK && !port_ok) begin
				reason_out_d = ept_pkg::REASON_PORT;
			end
			if (reason_out_d == ept_pkg::REASON_OK && addr_d == 32'd0) begin
				reason_out_d = ept_pkg::REASON_ZERO_ADDR;
			end
			priority if (reason_out_d == ept_pkg::REASON_OK) begin
				verdict_d = ept_pkg::VERDICT_IPV4_OK;
				addr_out_d = addr_d;
				port_out_d = port_acc_d[15:0];
			end else if (!dns_d.valid || (host_cnt_d != 8'd0 && dns_d.numeric)) begin
				verdict_d = ept_pkg::VERDICT_DNS_NOT_CANONICAL;
			end else if (!port_ok) begin
				verdict_d = ept_pkg::VERDICT_DNS_BAD_PORT;
			end else begin
				verdict_d = ept_pkg::VERDICT_DNS_OK;
				port_out_d = port_acc_d[15:0];
				hlen_out_d = host_cnt_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			colon_q <= '0;
			octet_idx_q <= '0;
			octet_acc_q <= '0;
			addr_q <= '0;
			ff_q <= '0;
			reason_q <= ept_pkg::REASON_OK;
			port_acc_q <= '0;
			host_cnt_q <= '0;
			label_len_q <= '0;
			dns_q <= ept_pkg::DNS_FLAGS_RESET;
		end else if (advance) begin
			if (is_last_s1) begin
				phase_q <= 1'b0;
				colon_q <= '0;
				octet_idx_q <= '0;
				octet_acc_q <= '0;
				addr_q <= '0;
				ff_q <= '0;
				reason_q <= ept_pkg::REASON_OK;
				port_acc_q <= '0;
				host_cnt_q <= '0;
				label_len_q <= '0;
				dns_q <= ept_pkg::DNS_FLAGS_RESET;
			end else begin
				phase_q <= phase_d;
				colon_q <= colon_d;
				octet_idx_q <= octet_idx_d;
				octet_acc_q <= octet_acc_d;
				addr_q <= addr_d;
				ff_q <= ff_d;
				reason_q <= reason_d;
				port_acc_q <= port_acc_d;
				host_cnt_q <= host_cnt_d;
				label_len_q <= label_len_d;
				dns_q <= dns_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && is_last_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last_s1) begin
			verdict_s2 <= verdict_d;
			ipv4_reason_s2 <= reason_out_d;
			ipv4_address_s2 <= addr_out_d;
			port_number_s2 <= port_out_d;
			hostname_length_s2 <= hlen_out_d;
		end
	end

	assign result.valid = valid_s2;
	assign result.verdict = verdict_s2;
	assign result.ipv4_reason = ipv4_reason_s2;
	assign result.ipv4_address = ipv4_address_s2;
	assign result.port_number = port_number_s2;
	assign result.hostname_length = hostname_length_s2;

`include "endpoint_text_parser_assert.svh"

	`EPT_ASSERT_IMPLIES(a_result_follows_last, $rose(valid_s2), $past(valid_s1 && is_last_s1),
		"result appeared without a last character")
	`EPT_ASSERT_IMPLIES(a_ipv4_ok_no_reason,
		valid_s2 && verdict_s2 == ept_pkg::VERDICT_IPV4_OK,
		ipv4_reason_s2 == ept_pkg::REASON_OK, "ipv4 verdict with a failure reason")
	`EPT_ASSERT_IMPLIES(a_address_only_ipv4,
		valid_s2 && verdict_s2 != ept_pkg::VERDICT_IPV4_OK,
		ipv4_address_s2 == 32'd0, "address reported on a non-ipv4 verdict")
	`EPT_ASSERT(a_counters_saturate,
		label_len_q <= ept_pkg::LABEL_SAT && colon_q <= ept_pkg::COLON_SAT,
		"label length or colon count past saturation")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_CHARS = 40;
	localparam int PHASE_TEXTS = 3;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_SPACING = 600;
	localparam int OCTET_MAX = 255;
	localparam int PORT_MAX = 65535;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_byte_t;

	typedef struct packed {
		ept_pkg::verdict_t     verdict;
		ept_pkg::ipv4_reason_t reason;
		logic [31:0]           addr;
		logic [15:0]           port;
		logic [7:0]            hlen;
	} endpoint_verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [7:0] cfg_wr_data;

	ept_text_if text_bus();
	ept_result_if result_bus();

	endpoint_text_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.text(text_bus),
		.result(result_bus)
	);

	logic [7:0] txt[$];
	text_byte_t pending_bytes[$];
	endpoint_verdict_t expected_verdicts[$];
	int err_count = 0;
	int cycle_count = 0;

	// parser state mirror
	logic [7:0] host_len_limit;
	logic in_port;
	int colons;
	int oct_idx;
	int oct_acc;
	int port_acc;
	int host_cnt;
	int lbl_len;
	logic [31:0] addr_acc;
	logic f_nonempty, f_multi, f_lead, f_bad;
	ept_pkg::ipv4_reason_t host_rsn;
	logic d_valid, d_numeric, d_prevh, d_starth, d_long;

	always #1 clk = ~clk;

	function automatic void add_char(logic [7:0] c);
		txt.insert(txt.size(), c);
	endfunction

	function automatic void clear_field();
		f_nonempty = 1'b0;
		f_multi = 1'b0;
		f_lead = 1'b0;
		f_bad = 1'b0;
	endfunction

	function automatic void clear_parse();
		in_port = 1'b0;
		colons = 0;
		oct_idx = 0;
		oct_acc = 0;
		port_acc = 0;
		host_cnt = 0;
		lbl_len = 0;
		addr_acc = '0;
		clear_field();
		host_rsn = ept_pkg::REASON_OK;
		d_valid = 1'b1;
		d_numeric = 1'b1;
		d_prevh = 1'b0;
		d_starth = 1'b0;
		d_long = 1'b0;
	endfunction

	function automatic void note_reason(ept_pkg::ipv4_reason_t r);
		if (host_rsn == ept_pkg::REASON_OK) begin
			host_rsn = r;
		end
	endfunction

	function automatic logic is_dec(logic [7:0] c);
		return (c >= ept_pkg::CHAR_ZERO) && (c <= ept_pkg::CHAR_NINE);
	endfunction

	function automatic int accumulate(int acc, logic [7:0] c, int limit);
		int nxt;
		nxt = acc;
		if (f_nonempty) begin
			f_multi = 1'b1;
		end else begin
			f_nonempty = 1'b1;
			if (c == ept_pkg::CHAR_ZERO) begin
				f_lead = 1'b1;
			end
		end
		if (!is_dec(c)) begin
			f_bad = 1'b1;
		end else if (acc < limit) begin
			nxt = acc * 10 + int'(c - ept_pkg::CHAR_ZERO);
			if (nxt > limit) begin
				nxt = limit;
			end
		end
		return nxt;
	endfunction

	function automatic logic field_good(int acc, int maxval);
		return f_nonempty && !f_bad && !(f_multi && f_lead) && (acc <= maxval);
	endfunction

	function automatic void end_label();
		if (lbl_len == 0 || lbl_len > int'(ept_pkg::MAX_LABEL_BYTES) || d_starth || d_prevh)
		begin
			d_valid = 1'b0;
		end
		lbl_len = 0;
		d_starth = 1'b0;
		d_prevh = 1'b0;
	endfunction

	function automatic void host_char(logic [7:0] c);
		logic dig;
		logic low;
		dig = is_dec(c);
		low = (c >= ept_pkg::CHAR_LOWER_A) && (c <= ept_pkg::CHAR_LOWER_Z);
		if (c == ept_pkg::CHAR_DOT && oct_idx < int'(ept_pkg::LAST_OCTET)) begin
			if (!field_good(oct_acc, OCTET_MAX)) begin
				note_reason(ept_pkg::REASON_OCTET);
			end
			addr_acc = {addr_acc[23:0], oct_acc[7:0]};
			oct_idx++;
			clear_field();
			oct_acc = 0;
		end else begin
			oct_acc = accumulate(oct_acc, c, int'(ept_pkg::OCTET_LIMIT));
		end
		if (host_cnt < int'(ept_pkg::HOST_COUNT_MAX)) begin
			host_cnt++;
		end else begin
			d_long = 1'b1;
		end
		if (!dig && c != ept_pkg::CHAR_DOT) begin
			d_numeric = 1'b0;
		end
		if (c == ept_pkg::CHAR_DOT) begin
			end_label();
		end else begin
			if (lbl_len == 0 && c == ept_pkg::CHAR_HYPHEN) begin
				d_starth = 1'b1;
			end
			if (lbl_len < int'(ept_pkg::LABEL_SAT)) begin
				lbl_len++;
			end
			d_prevh = (c == ept_pkg::CHAR_HYPHEN);
			if (!low && !dig && c != ept_pkg::CHAR_HYPHEN) begin
				d_valid = 1'b0;
			end
		end
	endfunction

	function automatic void close_host();
		if (oct_idx < int'(ept_pkg::LAST_OCTET) || !f_nonempty) begin
			note_reason(ept_pkg::REASON_MALFORMED);
		end else if (!field_good(oct_acc, OCTET_MAX)) begin
			note_reason(ept_pkg::REASON_OCTET);
		end else begin
			addr_acc = {addr_acc[23:0], oct_acc[7:0]};
		end
		end_label();
		if (d_long || host_cnt > int'(host_len_limit) ||
			host_cnt > int'(ept_pkg::MAX_NAME_BYTES)) begin
			d_valid = 1'b0;
		end
		clear_field();
		port_acc = 0;
	endfunction

	function automatic void parse_char(logic [7:0] c, logic last);
		endpoint_verdict_t v;
		logic port_good;
		if (c == ept_pkg::CHAR_COLON) begin
			if (!in_port) begin
				close_host();
				in_port = 1'b1;
			end
			if (colons < int'(ept_pkg::COLON_SAT)) begin
				colons++;
			end
		end else if (!in_port) begin
			host_char(c);
		end else begin
			port_acc = accumulate(port_acc, c, int'(ept_pkg::PORT_LIMIT));
		end
		if (last) begin
			v.addr = '0;
			v.port = '0;
			v.hlen = '0;
			if (colons != int'(ept_pkg::COLON_ONE)) begin
				v.reason = ept_pkg::REASON_COLON_COUNT;
				v.verdict = ept_pkg::VERDICT_DNS_NOT_CANONICAL;
			end else begin
				port_good = field_good(port_acc, PORT_MAX) && port_acc != 0;
				v.reason = host_rsn;
				if (v.reason == ept_pkg::REASON_OK && !port_good) begin
					v.reason = ept_pkg::REASON_PORT;
				end
				if (v.reason == ept_pkg::REASON_OK && addr_acc == '0) begin
					v.reason = ept_pkg::REASON_ZERO_ADDR;
				end
				if (v.reason == ept_pkg::REASON_OK) begin
					v.verdict = ept_pkg::VERDICT_IPV4_OK;
					v.addr = addr_acc;
					v.port = port_acc[15:0];
				end else if (!d_valid || (host_cnt > 0 && d_numeric)) begin
					v.verdict = ept_pkg::VERDICT_DNS_NOT_CANONICAL;
				end else if (!port_good) begin
					v.verdict = ept_pkg::VERDICT_DNS_BAD_PORT;
				end else begin
					v.verdict = ept_pkg::VERDICT_DNS_OK;
					v.port = port_acc[15:0];
					v.hlen = host_cnt[7:0];
				end
			end
			expected_verdicts.insert(expected_verdicts.size(), v);
			clear_parse();
		end
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i]);
		end
	endfunction

	function automatic void put_num(int n);
		put_str($sformatf("%0d", n));
	endfunction

	function automatic void put_label(int n);
		for (int i = 0; i < n; i++) begin
			add_char(ept_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25)));
		end
	endfunction

	function automatic void enqueue_text();
		text_byte_t b;
		foreach (txt[i]) begin
			b.ch = txt[i];
			b.last = (i == txt.size() - 1);
			pending_bytes.insert(pending_bytes.size(), b);
		end
		txt.delete();
	endfunction

	function automatic void add_text(string s);
		put_str(s);
		enqueue_text();
	endfunction

	function automatic void gen_port();
		case ($urandom_range(0, 15))
			0: put_num(0);
			1: put_num(1);
			2: put_num(PORT_MAX);
			3: put_num(PORT_MAX + 1);
			4: begin
				put_str("0");
				put_num($urandom_range(1, 9999));
			end
			5: ;
			6: put_num($urandom_range(100000, 99999999));
			7: put_str("8x");
			default: put_num($urandom_range(1, PORT_MAX));
		endcase
	endfunction

	function automatic void gen_octet();
		case ($urandom_range(0, 15))
			0: put_num(0);
			1: put_num(OCTET_MAX);
			2: put_num(OCTET_MAX + 1);
			3: begin
				put_str("0");
				put_num($urandom_range(0, 99));
			end
			4: ;
			5: put_num($urandom_range(300, 99999));
			default: put_num($urandom_range(0, OCTET_MAX));
		endcase
	endfunction

	function automatic void gen_ipv4();
		int n;
		case ($urandom_range(0, 9))
			0: n = 3;
			1: n = 5;
			default: n = 4;
		endcase
		for (int i = 0; i < n; i++) begin
			if (i != 0) begin
				put_str(".");
			end
			gen_octet();
		end
		put_str(":");
		gen_port();
	endfunction

	function automatic void gen_label();
		int len;
		int k;
		case ($urandom_range(0, 39))
			0: len = int'(ept_pkg::MAX_LABEL_BYTES);
			1: len = int'(ept_pkg::LABEL_SAT);
			default: len = $urandom_range(1, 10);
		endcase
		for (int i = 0; i < len; i++) begin
			k = $urandom_range(0, 39);
			if (k < 26) begin
				add_char(ept_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25)));
			end else if (k < 34) begin
				add_char(ept_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			end else if (k < 38) begin
				add_char(ept_pkg::CHAR_HYPHEN);
			end else if (k == 38) begin
				add_char(8'h41 + 8'($urandom_range(0, 25)));
			end else begin
				add_char(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	function automatic void gen_dns();
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			if (i != 0) begin
				put_str(".");
			end
			if ($urandom_range(0, 9) == 0) begin
				put_num($urandom_range(0, 999));
			end else begin
				gen_label();
			end
		end
		put_str(":");
		gen_port();
	endfunction

	function automatic void gen_noise();
		int n;
		n = $urandom_range(1, 16);
		for (int i = 0; i < n; i++) begin
			add_char(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1) == 0) begin
			txt[$urandom_range(0, n - 1)] = ept_pkg::CHAR_COLON;
		end
	endfunction

	function automatic void break_text();
		int pos;
		pos = $urandom_range(0, txt.size() - 1);
		case ($urandom_range(0, 2))
			0: txt[pos] = 8'($urandom_range(0, 255));
			1: txt.insert(pos, ept_pkg::CHAR_COLON);
			default: if (txt.size() > 1) txt.delete(pos);
		endcase
	endfunction

	task automatic add_directed();
		add_text("0.0.0.0:1");
		add_text("255.255.255.255:65535");
		add_text("1.2.3.4:0");
		add_text("256.1.1.1:80");
		add_text("01.1.1.1:80");
		add_text("1.2.3:80");
		add_text("1.2.3.4.5:80");
		add_text("1..3.4:80");
		add_text("1.2.3.:80");
		add_text("1.2.3.4");
		add_text("a:b:c");
		add_text("example.com:443");
		add_text("example.com:0");
		add_text("Example.com:443");
		add_text("-ab.com:1");
		add_text("ab-.com:1");
		add_text("a..b:1");
		add_text("a.b.:1");
		add_text("1.2.3.4:65536");
		add_text("1.2.3.4:080");
		add_text(":");
		add_text("x:99999999999");
		add_char(8'h00);
		add_char(8'hff);
		put_str(":1");
		enqueue_text();
		put_label(ept_pkg::MAX_LABEL_BYTES);
		put_str(".z.");
		put_label(ept_pkg::LABEL_SAT);
		put_str(":7");
		enqueue_text();
		for (int extra = 0; extra < 2; extra++) begin
			for (int i = 0; i < 3; i++) begin
				put_label(ept_pkg::MAX_LABEL_BYTES);
				put_str(".");
			end
			put_label(61 + extra);
			put_str(":1");
			enqueue_text();
		end
		for (int i = 0; i < 5; i++) begin
			put_label(ept_pkg::MAX_LABEL_BYTES);
			put_str(i == 4 ? ":9" : ".");
		end
		enqueue_text();
	endtask

	task automatic add_random();
		int chars;
		int texts;
		int pick;
		chars = 0;
		texts = 0;
		while (chars < PHASE_CHARS || texts < PHASE_TEXTS) begin
			pick = $urandom_range(0, 19);
			if (pick < 7) begin
				gen_ipv4();
			end else if (pick < 14) begin
				gen_dns();
			end else if (pick < 17) begin
				if (pick == 14) gen_ipv4(); else gen_dns();
				break_text();
			end else begin
				gen_noise();
			end
			chars += txt.size();
			texts++;
			enqueue_text();
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_verdicts.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(logic [7:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		host_len_limit = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// text transaction driver
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		text_byte_t nxt;
		if (!arst_n) begin
			text_bus.valid <= 1'b0;
			text_bus.text_char <= '0;
			text_bus.is_last <= 1'b0;
			burst_left = 1;
			gap_left = 0;
			clear_parse();
		end else begin
			if (text_bus.valid && text_bus.ready) begin
				nxt = pending_bytes.pop_front();
				parse_char(nxt.ch, nxt.last);
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				text_bus.valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				text_bus.valid <= 1'b1;
				text_bus.text_char <= pending_bytes[0].ch;
				text_bus.is_last <= pending_bytes[0].last;
			end else begin
				text_bus.valid <= 1'b0;
			end
		end
	end

	// result transaction monitor and ready driver
	int results_seen = 0;
	int next_hold_at = 20;
	int hold_left = 0;
	int mode_left = 0;
	int stall_mode = 0;

	always @(posedge clk or negedge arst_n) begin
		endpoint_verdict_t want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				results_seen++;
				if (expected_verdicts.size() == 0) begin
					$error("result transaction with no text pending");
					err_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (result_bus.verdict !== want.verdict) begin
						$error("verdict expected %0d got %0d", want.verdict, result_bus.verdict);
						err_count++;
					end
					if (result_bus.ipv4_reason !== want.reason) begin
						$error("ipv4_reason expected %0d got %0d", want.reason,
							result_bus.ipv4_reason);
						err_count++;
					end
					if (result_bus.ipv4_address !== want.addr) begin
						$error("ipv4_address expected %h got %h", want.addr,
							result_bus.ipv4_address);
						err_count++;
					end
					if (result_bus.port_number !== want.port) begin
						$error("port_number expected %0d got %0d", want.port,
							result_bus.port_number);
						err_count++;
					end
					if (result_bus.hostname_length !== want.hlen) begin
						$error("hostname_length expected %0d got %0d", want.hlen,
							result_bus.hostname_length);
						err_count++;
					end
				end
			end
			if (hold_left == 0 && results_seen >= next_hold_at) begin
				hold_left = LONG_HOLD;
				next_hold_at += HOLD_SPACING;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 160);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: result_bus.ready <= 1'b1;
					1: result_bus.ready <= ($urandom_range(0, 1) == 0);
					2: result_bus.ready <= ($urandom_range(0, 3) == 0);
					default: result_bus.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [7:0] limits[4];
		limits[0] = 8'd1;
		limits[1] = 8'd40;
		limits[2] = ept_pkg::MAX_NAME_BYTES;
		limits[3] = 8'd120;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		host_len_limit = ept_pkg::HOSTNAME_LEN_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		add_directed();
		foreach (limits[i]) begin
			wait_drained();
			write_limit(limits[i]);
			@(negedge clk);
			add_random();
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
